// File: rtl/core/positional_list_engine_assert.svh
// Assertion macros for the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  localparam int Capacity = 16;
  localparam int OpW      = 3;
  localparam int DataW    = 32;
  localparam int PosW     = 7;
  localparam int CountW   = 7;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INSERT_AT  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_DELETE_AT  = 3'd5,
    OP_READ_AT    = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [PosW-1:0]  idx;
    logic [DataW-1:0] value;
  } ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds, loads, or takes its left or right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell #(
  parameter int Idx = 0
) (
  input  wire logic                        clk_i,
  input  wire ple_pkg::ctrl_t              ctrl_i,
  input  wire logic [ple_pkg::DataW-1:0]   left_i,
  input  wire logic [ple_pkg::DataW-1:0]   right_i,
  output logic      [ple_pkg::DataW-1:0]   data_o,
  output logic      [ple_pkg::DataW-1:0]   tap_o
);

  localparam logic [ple_pkg::PosW-1:0] MyIdx = ple_pkg::PosW'(Idx);

  logic [ple_pkg::DataW-1:0] data_q;
  logic [ple_pkg::DataW-1:0] data_d;

  always_comb begin
    data_d = data_q;
    priority if (ctrl_i.ins && (MyIdx > ctrl_i.idx)) begin
      data_d = left_i;
    end else if (ctrl_i.ins && (MyIdx == ctrl_i.idx)) begin
      data_d = ctrl_i.value;
    end else if (ctrl_i.del && (MyIdx >= ctrl_i.idx)) begin
      data_d = right_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign tap_o  = (MyIdx == ctrl_i.idx) ? data_q : '0;

endmodule

`default_nettype wire

// File: rtl/core/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values held in a shifting chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfers on a rising edge with start_i high and busy_o low.
//   busy_o is always low: a new request may be issued every cycle.
//   opcode_i selects push front/back, insert at position_i, pop front/back,
//   delete at position_i or read at position_i (positions are 1-based).
//   Every request gives exactly one result, shown for one cycle with done_o
//   high on the cycle after the transfer: status_o, read_value_o and the
//   element count after the request. Throughput is 1 request per cycle;
//   an insert or delete shifts the cells from the addressed position onward
//   in that single cycle, and a read taps the addressed cell.
//   The receiver cannot stall; each result must be taken when shown.
//   Reset empties the list (count zero). Cell contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine #(
  parameter int Capacity = ple_pkg::Capacity
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [ple_pkg::OpW-1:0]       opcode_i,
  input  wire logic signed [ple_pkg::DataW-1:0] value_i,
  input  wire logic [ple_pkg::PosW-1:0]      position_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic signed [ple_pkg::DataW-1:0]   read_value_o,
  output logic [ple_pkg::CountW-1:0]         element_count_o
);

  localparam int CntW = $clog2(Capacity + 1);
  localparam int PosW = ple_pkg::PosW;
  localparam int DataW = ple_pkg::DataW;
  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q;
  ple_pkg::status_e status_q, status_d;
  logic [DataW-1:0] rdata_q, rdata_d;

  ple_pkg::ctrl_t ctrl;
  ple_pkg::op_e   op;
  logic           ins, del, rd_ok;
  logic [PosW-1:0] cnt_pos;
  logic [PosW:0]  pos_x, cnt_x;
  logic [DataW-1:0] tap_or;

  logic [DataW-1:0] cell_data [Capacity];
  logic [DataW-1:0] cell_tap  [Capacity];

  assign busy_o  = 1'b0;
  assign op      = ple_pkg::op_e'(opcode_i);
  assign cnt_pos = PosW'(cnt_q);
  assign pos_x   = {1'b0, position_i};
  assign cnt_x   = {1'b0, cnt_pos};

  always_comb begin
    ins      = 1'b0;
    del      = 1'b0;
    rd_ok    = 1'b0;
    ctrl.idx = '0;
    status_d = ple_pkg::ST_OK;
    unique case (op)
      ple_pkg::OP_PUSH_FRONT, ple_pkg::OP_PUSH_BACK, ple_pkg::OP_INSERT_AT: begin
        if (cnt_q >= CapCnt) begin
          status_d = ple_pkg::ST_FULL;
        end else if (op == ple_pkg::OP_PUSH_FRONT) begin
          ins = 1'b1;
        end else if (op == ple_pkg::OP_PUSH_BACK) begin
          ins      = 1'b1;
          ctrl.idx = cnt_pos;
        end else if (position_i == '0 || pos_x > cnt_x + 1'b1) begin
          status_d = ple_pkg::ST_BADPOS;
        end else begin
          ins      = 1'b1;
          ctrl.idx = position_i - 1'b1;
        end
      end
      ple_pkg::OP_POP_FRONT, ple_pkg::OP_POP_BACK, ple_pkg::OP_DELETE_AT,
      ple_pkg::OP_READ_AT: begin
        if (cnt_q == '0) begin
          status_d = ple_pkg::ST_EMPTY;
        end else if (op == ple_pkg::OP_POP_FRONT) begin
          del   = 1'b1;
          rd_ok = 1'b1;
        end else if (op == ple_pkg::OP_POP_BACK) begin
          del      = 1'b1;
          rd_ok    = 1'b1;
          ctrl.idx = cnt_pos - 1'b1;
        end else if (position_i == '0 || pos_x > cnt_x) begin
          status_d = ple_pkg::ST_BADPOS;
        end else begin
          del      = (op == ple_pkg::OP_DELETE_AT);
          rd_ok    = 1'b1;
          ctrl.idx = position_i - 1'b1;
        end
      end
      default: begin
      end
    endcase
    ctrl.ins   = start_i & ins;
    ctrl.del   = start_i & del;
    ctrl.value = value_i;
  end

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    logic [DataW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = value_i;
    end else begin : g_mid
      assign left = cell_data[g-1];
    end
    if (g == Capacity - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cell_data[g+1];
    end
    ple_cell #(
      .Idx(g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[g]),
      .tap_o  (cell_tap[g])
    );
  end

  always_comb begin
    tap_or = '0;
    for (int i = 0; i < Capacity; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.ins) begin
      cnt_d = cnt_q + 1'b1;
    end else if (ctrl.del) begin
      cnt_d = cnt_q - 1'b1;
    end
    rdata_d = rd_ok ? tap_or : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      done_q   <= 1'b0;
      status_q <= ple_pkg::ST_OK;
      rdata_q  <= '0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= start_i;
      if (start_i) begin
        status_q <= status_d;
        rdata_q  <= rdata_d;
      end
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign read_value_o    = rdata_q;
  assign element_count_o = ple_pkg::CountW'(cnt_q);

`include "positional_list_engine_assert.svh"

  `PLE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CapCnt, "element count above capacity")
  `PLE_ASSERT_NEXT(a_done_follows, start_i && !busy_o, done_o, "missing result strobe")
  `PLE_ASSERT_NOW(a_full_cnt, done_o && status_o == ple_pkg::ST_FULL,
                  element_count_o == ple_pkg::CountW'(Capacity), "full with room left")
  `PLE_ASSERT_NOW(a_rd_ok, done_o && read_value_o != '0, status_o == ple_pkg::ST_OK,
                  "read value on failed request")

endmodule

`default_nettype wire
